// ===== sv/haptic_force_renderer_assert.svh =====
// assertion macros for the haptic force renderer checker
`ifndef HAPTIC_FORCE_RENDERER_ASSERT_SVH
`define HAPTIC_FORCE_RENDERER_ASSERT_SVH

// same-cycle implication, off while in reset
`define HFR_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("haptic force renderer check failed");

// next-cycle implication, off while in reset
`define HFR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("haptic force renderer check failed");

// next-cycle implication, live through reset
`define HFR_ASSERT_NEXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("haptic force renderer check failed");

`endif

// ===== sv/hfr_pkg.sv =====
// shared types, constants and arithmetic helpers for the haptic force renderer
package hfr_pkg;

  localparam int POSITION_BITS_DEF = 16;
  localparam int VIB_DEPTH_DEF     = 4096;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FORCE_W    = 24;
  localparam int ROM_W      = 17;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MODE       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SPRING     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COULOMB    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_VISCOUS    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_GAIN  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WALL_POS   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_VIB_AMP    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_BAND_WIDTH = 3'd7;

  // mode codes
  localparam logic [2:0] MODE_SPRING  = 3'd0;
  localparam logic [2:0] MODE_COULOMB = 3'd1;
  localparam logic [2:0] MODE_VISCOUS = 3'd2;
  localparam logic [2:0] MODE_WALL    = 3'd3;
  localparam logic [2:0] MODE_HARD    = 3'd4;
  localparam logic [2:0] MODE_TEXTURE = 3'd5;

  // register reset values
  localparam logic [2:0]        MODE_RST        = MODE_HARD;
  localparam logic [15:0]       SPRING_RST      = 16'd5325;
  localparam logic [15:0]       COULOMB_RST     = 16'd2867;
  localparam logic [15:0]       VISCOUS_RST     = 16'd123;
  localparam logic [15:0]       WALL_GAIN_RST   = 16'd123;
  localparam logic signed [15:0] WALL_POS_RST   = 16'sd1024;
  localparam logic [15:0]       VIB_AMP_RST     = 16'd819;
  localparam logic [8:0]        BAND_WIDTH_RST  = 9'd123;

  // texture geometry: 1.5 cm span, width clamp
  localparam int BAND_SPAN = 1536;
  localparam logic [8:0] BAND_WIDTH_MAX = 9'd256;

  // decaying 24 Hz sinusoid recurrence, Q30
  localparam logic signed [63:0] ROM_C1 = 64'sd2118871471;
  localparam logic signed [63:0] ROM_C2 = 64'sd1069455435;
  localparam logic signed [31:0] ROM_Y1 = 32'sd160981213;

  localparam logic signed [63:0] F_MAX = 64'sd8388607;
  localparam logic signed [63:0] F_MIN = -64'sd8388608;

  typedef struct packed {
    logic [2:0]        mode;
    logic [15:0]       spring_gain;
    logic [15:0]       coulomb_level;
    logic [15:0]       viscous_gain;
    logic [15:0]       wall_gain;
    logic signed [15:0] wall_position;
    logic [15:0]       vibration_amplitude;
    logic [8:0]        texture_band_width;
  } cfg_t;

  typedef enum logic [1:0] {
    FILL_MUL,
    FILL_ACC,
    FILL_DONE
  } fill_state_t;

  // scale down by 2^s, round to nearest, ties away from zero
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                   input int unsigned s);
    logic [63:0] m;
    m = v[63] ? 64'(-v) : 64'(v);
    m = (m + (64'd1 << (s - 1))) >> s;
    return v[63] ? -$signed(m) : $signed(m);
  endfunction

  function automatic logic signed [FORCE_W-1:0] sat24(input logic signed [63:0] v);
    logic signed [63:0] c;
    c = (v > F_MAX) ? F_MAX : ((v < F_MIN) ? F_MIN : v);
    return c[FORCE_W-1:0];
  endfunction

endpackage

// ===== sv/hfr_ram.sv =====
// generic single write port ram with registered read
module hfr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== sv/hfr_rom_fill.sv =====
// sequencer that builds the impact sinusoid table after reset
module hfr_rom_fill #(
  parameter int DEPTH = hfr_pkg::VIB_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  output logic                       done,
  output logic                       wr_en,
  output logic [$clog2(DEPTH)-1:0]   wr_addr,
  output logic [hfr_pkg::ROM_W-1:0]  wr_data
);

  localparam int AW = $clog2(DEPTH);

  hfr_pkg::fill_state_t state_r, state_nxt;
  logic [AW-1:0]        n_r;
  logic signed [31:0]   a_r, b_r;
  logic signed [63:0]   p1_r;
  logic signed [31:0]   y;
  logic signed [63:0]   y_full;
  logic signed [63:0]   y_q15;
  logic                 last;

  assign last = (n_r == AW'(DEPTH - 1));

  always_comb begin
    y_full = hfr_pkg::rnd_shift(p1_r - hfr_pkg::ROM_C2 * a_r, 30);
    if (n_r == '0) begin
      y = '0;
    end else if (n_r == AW'(1)) begin
      y = hfr_pkg::ROM_Y1;
    end else begin
      y = y_full[31:0];
    end
    y_q15 = hfr_pkg::rnd_shift(64'(y), 15);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hfr_pkg::FILL_MUL:  state_nxt = hfr_pkg::FILL_ACC;
      hfr_pkg::FILL_ACC:  state_nxt = last ? hfr_pkg::FILL_DONE : hfr_pkg::FILL_MUL;
      hfr_pkg::FILL_DONE: state_nxt = hfr_pkg::FILL_DONE;
      default:            state_nxt = hfr_pkg::FILL_DONE;
    endcase
  end

  always_comb begin
    wr_en   = (state_r == hfr_pkg::FILL_ACC);
    done    = (state_r == hfr_pkg::FILL_DONE);
    wr_addr = n_r;
    wr_data = y_q15[hfr_pkg::ROM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hfr_pkg::FILL_MUL;
      n_r     <= '0;
      a_r     <= '0;
      b_r     <= hfr_pkg::ROM_Y1;
    end else begin
      state_r <= state_nxt;
      if (state_r == hfr_pkg::FILL_ACC) begin
        n_r <= n_r + AW'(1);
        if (n_r > AW'(1)) begin
          a_r <= b_r;
          b_r <= y;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == hfr_pkg::FILL_MUL) begin
      p1_r <= hfr_pkg::ROM_C1 * b_r;
    end
  end

endmodule

// ===== sv/hfr_datapath.sv =====
// four stage force pipeline: input, geometry and state, multiply, round and select
module hfr_datapath #(
  parameter int POSITION_BITS = hfr_pkg::POSITION_BITS_DEF,
  parameter int DEPTH         = hfr_pkg::VIB_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  hfr_pkg::cfg_t                       cfg,
  input  logic                                fill_done,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [POSITION_BITS-1:0]     in_position,
  input  logic [31:0]                         in_time_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hfr_pkg::FORCE_W-1:0]  out_force_out,
  output logic signed [hfr_pkg::FORCE_W-1:0]  out_spring_part,
  output logic signed [hfr_pkg::FORCE_W-1:0]  out_vibration_part,
  output logic signed [hfr_pkg::FORCE_W-1:0]  out_velocity,
  output logic                                out_in_contact,
  output logic                                rom_rd_en,
  output logic [$clog2(DEPTH)-1:0]            rom_rd_addr,
  input  logic signed [hfr_pkg::ROM_W-1:0]    rom_rd_data
);

  localparam int P   = POSITION_BITS;
  localparam int FW  = hfr_pkg::FORCE_W;
  localparam int AW  = $clog2(DEPTH);
  localparam int WW  = ((P > 16) ? P : 16) + 1;
  localparam int OW  = ((P + 1) > FW) ? (P + 1) : FW;
  localparam int PW  = OW + 17;
  localparam int VW  = hfr_pkg::ROM_W + 17;
  localparam int XW  = P + 5;

  // handshake
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_go, s2_go, s3_go;
  logic s1_free, s2_free, s3_free, o_free;
  logic in_acc;

  assign o_free  = !out_v_r || out_ready;
  assign s3_go   = s3_v_r && o_free;
  assign s3_free = !s3_v_r || o_free;
  assign s2_go   = s2_v_r && s3_free;
  assign s2_free = !s2_v_r || s3_free;
  assign s1_go   = s1_v_r && s2_free;
  assign s1_free = !s1_v_r || s2_free;
  assign in_ready = s1_free && fill_done;
  assign in_acc   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= in_acc || (s1_v_r && !s1_go);
      s2_v_r  <= s1_go || (s2_v_r && !s2_go);
      s3_v_r  <= s2_go || (s3_v_r && !s3_go);
      out_v_r <= s3_go || (out_v_r && !out_ready);
    end
  end

  // input stage
  logic signed [P-1:0] s1_pos_r;
  logic [31:0]         s1_time_r;

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pos_r  <= in_position;
      s1_time_r <= in_time_ms;
    end
  end

  // geometry, velocity and contact state
  logic signed [P-1:0]  last_pos_r;
  logic                 contact_r, contact_nxt;
  logic [31:0]          impact_r, impact_nxt;
  logic signed [WW-1:0] pos_w, wall_w, dw;
  logic                 touch;
  logic signed [P:0]    diff;
  logic signed [P+7:0]  d8, vel80;
  logic signed [FW-1:0] vel;
  logic [31:0]          elapsed;
  logic                 t_ok;
  logic [8:0]           wc;
  logic signed [XW-1:0] x, wx, g, w10, lo0, hi0, lo1, hi1, lo2, hi2;
  logic                 band;
  logic [15:0]          gain;
  logic signed [OW-1:0] opnd;

  always_comb begin
    pos_w  = WW'(s1_pos_r);
    wall_w = WW'(cfg.wall_position);
    dw     = pos_w - wall_w;
    touch  = !dw[WW-1];
    diff   = (P+1)'(s1_pos_r) - (P+1)'(last_pos_r);
    d8     = (P+8)'(diff);
    vel80  = (d8 <<< 6) + (d8 <<< 4);
    vel    = hfr_pkg::sat24(64'(vel80));
  end

  always_comb begin
    contact_nxt = contact_r;
    impact_nxt  = impact_r;
    if (cfg.mode == hfr_pkg::MODE_HARD) begin
      if (!touch) begin
        contact_nxt = 1'b0;
      end else if (!contact_r) begin
        contact_nxt = 1'b1;
        impact_nxt  = s1_time_r;
      end
    end
    elapsed     = s1_time_r - impact_nxt;
    t_ok        = (elapsed < 32'(DEPTH));
    rom_rd_addr = t_ok ? elapsed[AW-1:0] : '0;
    rom_rd_en   = s1_go;
  end

  always_comb begin
    wc  = (cfg.texture_band_width > hfr_pkg::BAND_WIDTH_MAX) ?
          hfr_pkg::BAND_WIDTH_MAX : cfg.texture_band_width;
    x   = (XW'(s1_pos_r) <<< 3) + (XW'(s1_pos_r) <<< 1);
    wx  = XW'($signed({1'b0, wc}));
    g   = XW'(hfr_pkg::BAND_SPAN) - ((wx <<< 2) + (wx <<< 1));
    w10 = (wx <<< 3) + (wx <<< 1);
    lo0 = g;
    hi0 = g + w10;
    lo1 = (g <<< 1) + g + w10;
    hi1 = lo1 + w10;
    lo2 = (g <<< 2) + g + (w10 <<< 1);
    hi2 = lo2 + w10;
    band = (x > lo0 && x <= hi0) || (x < -lo0 && x >= -hi0) ||
           (x > lo1 && x <= hi1) || (x < -lo1 && x >= -hi1) ||
           (x > lo2 && x <= hi2) || (x < -lo2 && x >= -hi2);
  end

  always_comb begin
    case (cfg.mode)
      hfr_pkg::MODE_VISCOUS, hfr_pkg::MODE_TEXTURE: begin
        gain = cfg.viscous_gain;
        opnd = OW'(vel);
      end
      hfr_pkg::MODE_WALL, hfr_pkg::MODE_HARD: begin
        gain = cfg.wall_gain;
        opnd = OW'(dw);
      end
      default: begin
        gain = cfg.spring_gain;
        opnd = OW'(s1_pos_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_pos_r <= '0;
      contact_r  <= 1'b0;
      impact_r   <= '0;
    end else if (s1_go) begin
      last_pos_r <= s1_pos_r;
      contact_r  <= contact_nxt;
      impact_r   <= impact_nxt;
    end
  end

  logic [15:0]          s2_gain_r;
  logic signed [OW-1:0] s2_opnd_r;
  logic signed [FW-1:0] s2_vel_r;
  logic                 s2_touch_r, s2_band_r, s2_tok_r;

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_gain_r  <= gain;
      s2_opnd_r  <= opnd;
      s2_vel_r   <= vel;
      s2_touch_r <= touch;
      s2_band_r  <= band;
      s2_tok_r   <= t_ok;
    end
  end

  // multiply stage
  logic signed [PW-1:0] prod;
  logic signed [VW-1:0] vprod;

  always_comb begin
    prod  = $signed({1'b0, s2_gain_r}) * s2_opnd_r;
    vprod = $signed({1'b0, cfg.vibration_amplitude}) * rom_rd_data;
  end

  logic signed [PW-1:0] s3_prod_r;
  logic signed [VW-1:0] s3_vprod_r;
  logic signed [FW-1:0] s3_vel_r;
  logic                 s3_touch_r, s3_band_r, s3_tok_r;

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3_prod_r  <= prod;
      s3_vprod_r <= vprod;
      s3_vel_r   <= s2_vel_r;
      s3_touch_r <= s2_touch_r;
      s3_band_r  <= s2_band_r;
      s3_tok_r   <= s2_tok_r;
    end
  end

  // round, saturate and select by mode
  logic signed [FW-1:0] fgain, vib_val, clev;
  logic signed [FW-1:0] force_nxt, spring_nxt, vib_nxt;
  logic                 vel_pos, vel_neg;

  always_comb begin
    fgain   = hfr_pkg::sat24(-hfr_pkg::rnd_shift(64'(s3_prod_r), 10));
    vib_val = s3_tok_r ? hfr_pkg::sat24(hfr_pkg::rnd_shift(64'(s3_vprod_r), 15)) : '0;
    clev    = FW'($signed({1'b0, cfg.coulomb_level}));
    vel_neg = s3_vel_r[FW-1];
    vel_pos = !vel_neg && (s3_vel_r != '0);
    force_nxt  = '0;
    spring_nxt = '0;
    vib_nxt    = '0;
    case (cfg.mode)
      hfr_pkg::MODE_SPRING, hfr_pkg::MODE_VISCOUS: force_nxt = fgain;
      hfr_pkg::MODE_COULOMB: begin
        if (vel_pos) begin
          force_nxt = -clev;
        end else if (vel_neg) begin
          force_nxt = clev;
        end
      end
      hfr_pkg::MODE_WALL: begin
        if (s3_touch_r) begin
          force_nxt = fgain;
        end
      end
      hfr_pkg::MODE_HARD: begin
        if (s3_touch_r) begin
          spring_nxt = fgain;
          vib_nxt    = vib_val;
          force_nxt  = hfr_pkg::sat24(64'(fgain) + 64'(vib_val));
        end
      end
      hfr_pkg::MODE_TEXTURE: begin
        if (s3_band_r) begin
          force_nxt = fgain;
        end
      end
      default: force_nxt = '0;
    endcase
  end

  logic signed [FW-1:0] force_r, spring_r, vib_r, vel_r;
  logic                 contact_out_r;

  always_ff @(posedge clk) begin
    if (s3_go) begin
      force_r       <= force_nxt;
      spring_r      <= spring_nxt;
      vib_r         <= vib_nxt;
      vel_r         <= s3_vel_r;
      contact_out_r <= s3_touch_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_force_out      = force_r;
  assign out_spring_part    = spring_r;
  assign out_vibration_part = vib_r;
  assign out_velocity       = vel_r;
  assign out_in_contact     = contact_out_r;

endmodule

// ===== sv/haptic_force_renderer.sv =====
// top level of the haptic force renderer: config registers, table fill and force pipeline
//
//   channel   direction  handshake               payload
//   in        sink       in_valid / in_ready     in_position, in_time_ms
//   out       source     out_valid / out_ready   out_force_out, out_spring_part,
//                                                out_vibration_part, out_velocity,
//                                                out_in_contact
//   cfg       sink       cfg_wr_en               cfg_index, cfg_data
//
// one word accepted per cycle while in_ready is high; each result passes the input,
// geometry, multiply and output registers; after reset the sinusoid table is built entry
// by entry (recurrence multiplier) with in_ready low; config writes are taken throughout
// out_ready low holds the output word; the three inner stages keep filling and in_ready
// falls only when all of them hold a word
module haptic_force_renderer #(
  parameter int POSITION_BITS         = hfr_pkg::POSITION_BITS_DEF,
  parameter int VIBRATION_TABLE_DEPTH = hfr_pkg::VIB_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_wr_en,
  input  logic [hfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hfr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [POSITION_BITS-1:0]     in_position,
  input  logic [31:0]                         in_time_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [hfr_pkg::FORCE_W-1:0]  out_force_out,
  output logic signed [hfr_pkg::FORCE_W-1:0]  out_spring_part,
  output logic signed [hfr_pkg::FORCE_W-1:0]  out_vibration_part,
  output logic signed [hfr_pkg::FORCE_W-1:0]  out_velocity,
  output logic                                out_in_contact
);

  localparam int AW = $clog2(VIBRATION_TABLE_DEPTH);

  hfr_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode                <= hfr_pkg::MODE_RST;
      cfg_r.spring_gain         <= hfr_pkg::SPRING_RST;
      cfg_r.coulomb_level       <= hfr_pkg::COULOMB_RST;
      cfg_r.viscous_gain        <= hfr_pkg::VISCOUS_RST;
      cfg_r.wall_gain           <= hfr_pkg::WALL_GAIN_RST;
      cfg_r.wall_position       <= hfr_pkg::WALL_POS_RST;
      cfg_r.vibration_amplitude <= hfr_pkg::VIB_AMP_RST;
      cfg_r.texture_band_width  <= hfr_pkg::BAND_WIDTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        hfr_pkg::CFG_MODE:       cfg_r.mode                <= cfg_data[2:0];
        hfr_pkg::CFG_SPRING:     cfg_r.spring_gain         <= cfg_data;
        hfr_pkg::CFG_COULOMB:    cfg_r.coulomb_level       <= cfg_data;
        hfr_pkg::CFG_VISCOUS:    cfg_r.viscous_gain        <= cfg_data;
        hfr_pkg::CFG_WALL_GAIN:  cfg_r.wall_gain           <= cfg_data;
        hfr_pkg::CFG_WALL_POS:   cfg_r.wall_position       <= $signed(cfg_data);
        hfr_pkg::CFG_VIB_AMP:    cfg_r.vibration_amplitude <= cfg_data;
        hfr_pkg::CFG_BAND_WIDTH: cfg_r.texture_band_width  <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  logic                              fill_done;
  logic                              rom_wr_en;
  logic [AW-1:0]                     rom_wr_addr;
  logic [hfr_pkg::ROM_W-1:0]         rom_wr_data;
  logic                              rom_rd_en;
  logic [AW-1:0]                     rom_rd_addr;
  logic [hfr_pkg::ROM_W-1:0]         rom_rd_data;

  hfr_rom_fill #(
    .DEPTH (VIBRATION_TABLE_DEPTH)
  ) u_fill (
    .clk     (clk),
    .rst_n   (rst_n),
    .done    (fill_done),
    .wr_en   (rom_wr_en),
    .wr_addr (rom_wr_addr),
    .wr_data (rom_wr_data)
  );

  hfr_ram #(
    .WIDTH (hfr_pkg::ROM_W),
    .DEPTH (VIBRATION_TABLE_DEPTH)
  ) u_rom (
    .clk     (clk),
    .wr_en   (rom_wr_en),
    .wr_addr (rom_wr_addr),
    .wr_data (rom_wr_data),
    .rd_en   (rom_rd_en),
    .rd_addr (rom_rd_addr),
    .rd_data (rom_rd_data)
  );

  hfr_datapath #(
    .POSITION_BITS (POSITION_BITS),
    .DEPTH         (VIBRATION_TABLE_DEPTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .fill_done          (fill_done),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_position        (in_position),
    .in_time_ms         (in_time_ms),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_force_out      (out_force_out),
    .out_spring_part    (out_spring_part),
    .out_vibration_part (out_vibration_part),
    .out_velocity       (out_velocity),
    .out_in_contact     (out_in_contact),
    .rom_rd_en          (rom_rd_en),
    .rom_rd_addr        (rom_rd_addr),
    .rom_rd_data        ($signed(rom_rd_data))
  );

endmodule

// ===== sv/hfr_checker.sv =====
// port level checks for the haptic force renderer, bound to the top level
`include "haptic_force_renderer_assert.svh"

module hfr_checker #(
  parameter int POSITION_BITS = hfr_pkg::POSITION_BITS_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                cfg_wr_en,
  input logic [hfr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input logic [hfr_pkg::CFG_DATA_W-1:0]      cfg_data,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic signed [POSITION_BITS-1:0]     in_position,
  input logic [31:0]                         in_time_ms,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [hfr_pkg::FORCE_W-1:0]  out_force_out,
  input logic signed [hfr_pkg::FORCE_W-1:0]  out_spring_part,
  input logic signed [hfr_pkg::FORCE_W-1:0]  out_vibration_part,
  input logic signed [hfr_pkg::FORCE_W-1:0]  out_velocity,
  input logic                                out_in_contact
);

  // table fill blocks input and empties the pipeline right after reset
  `HFR_ASSERT_NEXT_ANY(a_reset_quiet, !rst_n, !in_ready && !out_valid)

  // surface parts only exist while in contact
  `HFR_ASSERT_SAME(a_parts_need_contact, out_valid && !out_in_contact, out_spring_part == '0 && out_vibration_part == '0)

  // stalled word stays
  `HFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_force_out) && $stable(out_velocity))

  // surface force without vibration is the spring alone
  `HFR_ASSERT_SAME(a_parts_sum, out_valid && out_spring_part != '0 && out_vibration_part == '0, out_force_out == out_spring_part)

endmodule

bind haptic_force_renderer hfr_checker #(.POSITION_BITS(POSITION_BITS)) u_hfr_checker (.*);
